// ===== hdl/arpc_pkg.sv =====
`default_nettype none

package arpc_pkg;

    // Table geometry.
    localparam int ENTRIES = 128;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths.
    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int AGE_W    = 9;
    localparam int TMO_W    = 8;
    localparam int SLOT_W   = 7;
    localparam int EXP_W    = 8;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 2;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
    localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};

    // Byte address of the timeout register on the APB port.
    localparam logic [2:0] REG_TIMEOUT = 3'd0;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_TICK   = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_FULL     = 3'd3,
        ST_TICK     = 3'd4
    } t_status;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic             start;     // latch a new request, clear accumulators
        logic             scan;      // one slot is visited this cycle
        logic [IDX_W-1:0] idx;       // slot visited this cycle
        logic             load_out;  // move the finished answer to the output register
    } t_cmd;

    // Reported slot number: the low bits of the slot, zero extended if the table is small.
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/arpc_ctrl.sv =====
`default_nettype none

module arpc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic          i_m_tready,
    output logic               o_m_tvalid,
    output arpc_pkg::t_cmd     o_cmd
);
    import arpc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;
    logic             r_m_tvalid;
    logic             accept;
    logic             load_out;
    logic             last_slot;

    assign accept    = i_s_tvalid && (r_state == S_IDLE);
    assign load_out  = (r_state == S_DONE) && (!r_m_tvalid || i_m_tready);
    assign last_slot = (r_idx == IDX_W'(ENTRIES - 1));

    assign o_s_tready     = (r_state == S_IDLE);
    assign o_m_tvalid     = r_m_tvalid;
    assign o_cmd.start    = accept;
    assign o_cmd.scan     = (r_state == S_SCAN);
    assign o_cmd.idx      = r_idx;
    assign o_cmd.load_out = load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (load_out) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (last_slot) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FLUSH: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/arpc_dp.sv =====
`default_nettype none

module arpc_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire arpc_pkg::t_cmd               i_cmd,
    input  wire logic [arpc_pkg::OP_W-1:0]    i_opcode,
    input  wire logic [arpc_pkg::IP_W-1:0]    i_ip_addr,
    input  wire logic [arpc_pkg::MAC_W-1:0]   i_mac_addr,
    input  wire logic [arpc_pkg::TMO_W-1:0]   i_timeout,
    output logic [arpc_pkg::STATUS_W-1:0]     o_status,
    output logic [arpc_pkg::MAC_W-1:0]        o_found_mac,
    output logic [arpc_pkg::SLOT_W-1:0]       o_slot_index,
    output logic [arpc_pkg::EXP_W-1:0]        o_expired_count
);
    import arpc_pkg::*;

    // Entry storage: address and MAC together, age apart since a tick rewrites only the age.
    logic [IP_W+MAC_W-1:0] mem_addr [ENTRIES];
    logic [AGE_W-1:0]      mem_age  [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;

    // Request.
    t_opcode          r_op;
    logic [IP_W-1:0]  r_ip;
    logic [MAC_W-1:0] r_mac;

    // Read stage.
    logic [IP_W+MAC_W-1:0] r_rd_addr;
    logic [AGE_W-1:0]      r_rd_age;
    logic                  r_p_act;
    logic                  r_p_vld;
    logic [IDX_W-1:0]      r_p_idx;

    // Accumulators.
    logic             r_hit;
    logic             r_found;
    logic [IDX_W-1:0] r_slot;
    logic [MAC_W-1:0] r_fmac;
    logic [EXP_W-1:0] r_exp;

    // Output register.
    logic [STATUS_W-1:0] r_status;
    logic [MAC_W-1:0]    r_out_mac;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [EXP_W-1:0]    r_out_exp;

    logic             ins_now;
    logic             tick_now;
    logic             look_match;
    logic [AGE_W-1:0] new_age;
    logic             expire;
    logic             age_we;
    logic [IDX_W-1:0] age_wa;
    logic [AGE_W-1:0] age_wd;

    assign ins_now    = i_cmd.scan && (r_op == OP_INSERT) && !r_found && !r_valid[i_cmd.idx];
    assign tick_now   = r_p_act && r_p_vld && (r_op == OP_TICK);
    assign look_match = r_p_act && r_p_vld && (r_op == OP_LOOKUP)
                        && (r_rd_addr[IP_W+MAC_W-1:MAC_W] == r_ip);
    assign new_age    = (r_rd_age == AGE_MAX) ? r_rd_age : r_rd_age + 1'b1;
    assign expire     = new_age > {1'b0, i_timeout};

    assign age_we = ins_now || tick_now;
    assign age_wa = ins_now ? i_cmd.idx : r_p_idx;
    assign age_wd = ins_now ? '0 : new_age;

    always_ff @(posedge i_clk) begin
        if (ins_now) begin
            mem_addr[i_cmd.idx] <= {r_ip, r_mac};
        end
        if (age_we) begin
            mem_age[age_wa] <= age_wd;
        end
        r_rd_addr <= mem_addr[i_cmd.idx];
        r_rd_age  <= mem_age[i_cmd.idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_p_act <= 1'b0;
        end else begin
            r_p_act <= i_cmd.scan;
            if (ins_now) begin
                r_valid[i_cmd.idx] <= 1'b1;
            end
            if (tick_now && expire) begin
                r_valid[r_p_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_vld <= r_valid[i_cmd.idx];
        r_p_idx <= i_cmd.idx;
        if (i_cmd.start) begin
            r_op    <= t_opcode'(i_opcode);
            r_ip    <= i_ip_addr;
            r_mac   <= i_mac_addr;
            r_hit   <= 1'b0;
            r_found <= 1'b0;
            r_slot  <= '0;
            r_fmac  <= '0;
            r_exp   <= '0;
        end else begin
            if (ins_now) begin
                r_found <= 1'b1;
                r_slot  <= i_cmd.idx;
            end
            if (look_match) begin
                r_hit  <= 1'b1;
                r_slot <= r_p_idx;
                r_fmac <= r_rd_addr[MAC_W-1:0];
            end
            if (tick_now && expire && (r_exp != EXP_MAX)) begin
                r_exp <= r_exp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_mac  <= '0;
            r_out_slot <= '0;
            r_out_exp  <= '0;
            case (r_op)
                OP_LOOKUP: begin
                    r_status <= r_hit ? ST_HIT : ST_MISS;
                    if (r_hit) begin
                        r_out_mac  <= r_fmac;
                        r_out_slot <= to_slot(r_slot);
                    end
                end
                OP_INSERT: begin
                    r_status <= r_found ? ST_INSERTED : ST_FULL;
                    if (r_found) begin
                        r_out_slot <= to_slot(r_slot);
                    end
                end
                OP_TICK: begin
                    r_status  <= ST_TICK;
                    r_out_exp <= r_exp;
                end
                default: begin
                    r_status <= ST_MISS;
                end
            endcase
        end
    end

    assign o_status        = r_status;
    assign o_found_mac     = r_out_mac;
    assign o_slot_index    = r_out_slot;
    assign o_expired_count = r_out_exp;

endmodule

`default_nettype wire

// ===== hdl/arp_cache_table.sv =====
`default_nettype none

// ARP cache: a table of IPv4-to-MAC entries with aging. Each request beat on the slave
// stream carries an opcode in s_tuser (0 lookup, 1 insert, 2 one-second tick) and gives
// exactly one answer beat on the master stream. A lookup answers with the MAC of the
// highest-numbered valid entry whose address matches, or a miss. An insert takes the
// lowest-numbered free entry and reports its slot, or reports the table full; duplicates
// are not filtered. A tick ages every valid entry by one (saturating) and drops entries
// whose age then exceeds the timeout register, reporting how many were dropped. Opcode 3
// changes nothing and answers miss. Every request walks all ENTRIES slots of the entry
// memory one slot per cycle through a registered read port before the answer beat, and
// the next request is taken in the cycle after the answer has been loaded into the output
// register, even while that answer still waits on m_tready. Valid marks are cleared by
// reset; the table is usable right after reset. The timeout register sits at byte
// address 0 of the APB port (reset value 15) and should only be written while no request
// is in flight.
module arp_cache_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // [31:0] ip_addr, [79:32] mac_addr
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    // Answer stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [47:0] found_mac, [54:48] slot_index,
                                        // [62:55] expired_count, [63] zero
    output logic [2:0]       m_tuser,   // [2:0] status
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import arpc_pkg::*;

    t_cmd              cmd;
    logic [TMO_W-1:0]  r_timeout;
    logic [MAC_W-1:0]  found_mac;
    logic [SLOT_W-1:0] slot_index;
    logic [EXP_W-1:0]  expired_count;
    logic              reg_sel;

    // Only one register exists; the word address bit picks it, the byte offset is ignored.
    assign reg_sel = (paddr[2] == REG_TIMEOUT[2]);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(32 - TMO_W){1'b0}}, r_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TMO_W'(15);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_timeout <= pwdata[TMO_W-1:0];
        end
    end

    // Sequencer: walks the slots and owns both handshakes.
    arpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_cmd      (cmd)
    );

    // Datapath: entry memories, valid marks, compare and aging logic, answer register.
    arpc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_opcode        (s_tuser),
        .i_ip_addr       (s_tdata[31:0]),
        .i_mac_addr      (s_tdata[79:32]),
        .i_timeout       (r_timeout),
        .o_status        (m_tuser),
        .o_found_mac     (found_mac),
        .o_slot_index    (slot_index),
        .o_expired_count (expired_count)
    );

    assign m_tdata = {1'b0, expired_count, slot_index, found_mac};

endmodule

`default_nettype wire

// ===== hdl/arpc_chk.sv =====
`default_nettype none

module arpc_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [2:0]  m_tuser
);
    import arpc_pkg::*;

    // One request at a time: after a request is taken, no other is taken next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted back to back");

    // A stalled answer stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("answer changed while stalled");

    // Only a hit carries a MAC.
    a_mac_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != ST_HIT) |-> (m_tdata[47:0] == 48'd0))
        else $error("MAC reported without a hit");

    // Only a tick reports expired entries, and a tick reports no slot.
    a_tick_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ((m_tuser == ST_TICK) ? (m_tdata[54:48] == 7'd0)
                                           : (m_tdata[62:55] == 8'd0)))
        else $error("tick fields inconsistent with status");

endmodule

bind arp_cache_table arpc_chk u_arpc_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
